// ===== design/teq_pkg.sv =====
// ----------------------------------------------------------------------------
// Timed event heap queue package
// Shared types, codes and sizes for the heap queue and its entry RAM.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int CAPACITY    = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int OCC_W       = $clog2(CAPACITY + 1);
    localparam int PW          = IDX_W + 2;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 48;
    localparam int WORD_W      = 32;

    typedef struct packed {
        logic [TIME_W-1:0] trig;
        logic [WORD_W-1:0] ident;
        logic [WORD_W-1:0] tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ACT_SCHEDULE = 2'd0,
        ACT_CANCEL   = 2'd1,
        ACT_TICK     = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        KIND_SCHEDULED = 3'd0,
        KIND_CANCELLED = 3'd1,
        KIND_NOT_FOUND = 3'd2,
        KIND_FIRED     = 3'd3,
        KIND_FULL      = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_UP_PUT,
        ST_DN_L,
        ST_DN_R,
        ST_DN_CMP,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_TICK_EMIT,
        ST_TICK_POP,
        ST_TICK_LAST,
        ST_TICK_END,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_CAN_LAST,
        ST_EMIT_FINAL
    } state_t;

endpackage

// ===== design/teq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module teq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/timed_event_heap_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Timed event heap queue unit
// Binary min-heap of timed events with schedule, cancel and tick commands.
// ----------------------------------------------------------------------------
// Usage: one command is taken per transfer on the s_ channel (s_action selects
// schedule, cancel or tick). Results leave through a registered m_ channel;
// m_last_of_run marks the final result of a command. A schedule or cancel
// returns exactly one result, a tick returns one result per fired event (at
// most 32, possibly none), and the unused action code returns nothing.
// All heap entries live in one single-port-read RAM, and a small sequencer
// moves a hole through the heap one level at a time, so every level of a sift
// costs one RAM read plus a compare (two reads on the way down).
// The block accepts no new command until the current one is finished.
// Reset clears the occupancy and the ID counter; the RAM needs no clearing
// because entries at or above the occupancy are never read.
// A stalled receiver simply holds the sequencer in its emit state until the
// output register is free again; no result is ever dropped.
// ----------------------------------------------------------------------------
module timed_event_heap_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [47:0] s_trigger_time,
    input  logic [31:0] s_event_payload,
    input  logic [31:0] s_cancel_id,
    input  logic [47:0] s_current_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_result_kind,
    output logic [31:0] m_evt_ident,
    output logic [31:0] m_payload_out,
    output logic        m_last_of_run
);

    // Sequencer and command state.
    teq_pkg::state_t                 state_reg, state_next;
    teq_pkg::action_t                mode_reg, mode_next;
    logic [teq_pkg::OCC_W-1:0]       occ_reg, occ_next;
    logic [31:0]                     last_id_reg, last_id_next;
    logic [teq_pkg::IDX_W-1:0]       pos_reg, pos_next;
    logic [teq_pkg::IDX_W-1:0]       start_reg, start_next;
    logic [teq_pkg::IDX_W-1:0]       scan_reg, scan_next;
    logic                            has_right_reg, has_right_next;
    logic [teq_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            have_pend_reg, have_pend_next;

    // Payload registers.
    teq_pkg::entry_t                 x_reg, x_next;
    teq_pkg::entry_t                 left_reg, left_next;
    teq_pkg::entry_t                 root_reg, root_next;
    logic [31:0]                     cid_reg, cid_next;
    logic [47:0]                     now_reg, now_next;
    teq_pkg::kind_t                  pend_kind_reg, pend_kind_next;
    logic [31:0]                     pend_id_reg, pend_id_next;
    logic [31:0]                     pend_tag_reg, pend_tag_next;

    // Output register.
    logic                            m_valid_reg, m_valid_next;
    teq_pkg::kind_t                  m_kind_reg, m_kind_next;
    logic [31:0]                     m_id_reg, m_id_next;
    logic [31:0]                     m_tag_reg, m_tag_next;
    logic                            m_last_reg, m_last_next;

    // RAM port.
    logic                            ram_we;
    logic [teq_pkg::IDX_W-1:0]       ram_waddr, ram_raddr;
    teq_pkg::entry_t                 ram_wdata;
    logic [teq_pkg::ENTRY_W-1:0]     ram_rdata;
    teq_pkg::entry_t                 rd_entry;

    // Index helpers.
    logic [teq_pkg::IDX_W-1:0]       parent_idx;
    logic [teq_pkg::PW-1:0]          left_w, right_w, occ_w;
    logic [teq_pkg::OCC_W-1:0]       occ_m1;
    logic [teq_pkg::OCC_W-1:0]       scan_p1;
    logic                            out_free, accept, full;
    logic                            up_less, right_pick, dn_swap;
    teq_pkg::entry_t                 pick_entry;
    logic [teq_pkg::IDX_W-1:0]       pick_idx;
    logic [31:0]                     id_inc, id_new;

    teq_ram #(
        .WIDTH (teq_pkg::ENTRY_W),
        .DEPTH (teq_pkg::CAPACITY)
    ) u_heap_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_entry   = teq_pkg::entry_t'(ram_rdata);
    assign parent_idx = teq_pkg::IDX_W'((pos_reg - 1'b1) >> 1);
    assign left_w     = {1'b0, pos_reg, 1'b1};
    assign right_w    = left_w + 1'b1;
    assign occ_w      = teq_pkg::PW'(occ_reg);
    assign occ_m1     = occ_reg - 1'b1;
    assign scan_p1    = teq_pkg::OCC_W'(scan_reg) + 1'b1;
    assign out_free   = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign full       = (occ_reg >= teq_pkg::OCC_W'(teq_pkg::CAPACITY));
    assign id_inc     = last_id_reg + 1'b1;
    assign id_new     = (id_inc == 32'd0) ? 32'd1 : id_inc;

    // The moving element climbs while it is strictly smaller than its parent.
    assign up_less    = (x_reg.trig < rd_entry.trig);
    // On the way down, the right child wins a tie.
    assign right_pick = has_right_reg && (left_reg.trig >= rd_entry.trig);
    assign pick_entry = right_pick ? rd_entry : left_reg;
    assign pick_idx   = right_pick ? teq_pkg::IDX_W'(right_w) : teq_pkg::IDX_W'(left_w);
    assign dn_swap    = (x_reg.trig > pick_entry.trig);

    assign s_ready       = (state_reg == teq_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_evt_ident   = m_id_reg;
    assign m_payload_out = m_tag_reg;
    assign m_last_of_run = m_last_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            teq_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_action)
                        teq_pkg::ACT_SCHEDULE: begin
                            if (full) begin
                                state_next = teq_pkg::ST_EMIT_FINAL;
                            end else if (occ_reg == '0) begin
                                state_next = teq_pkg::ST_UP_PUT;
                            end else begin
                                state_next = teq_pkg::ST_UP_RD;
                            end
                        end
                        teq_pkg::ACT_CANCEL: begin
                            if (s_cancel_id == 32'd0 || occ_reg == '0) begin
                                state_next = teq_pkg::ST_EMIT_FINAL;
                            end else begin
                                state_next = teq_pkg::ST_SCAN_RD;
                            end
                        end
                        teq_pkg::ACT_TICK: state_next = teq_pkg::ST_TICK_RD;
                        default:           state_next = teq_pkg::ST_IDLE;
                    endcase
                end
            end
            teq_pkg::ST_UP_RD: state_next = teq_pkg::ST_UP_CMP;
            teq_pkg::ST_UP_CMP: begin
                if (up_less) begin
                    state_next = (parent_idx == '0) ? teq_pkg::ST_UP_PUT : teq_pkg::ST_UP_RD;
                end else if (mode_reg == teq_pkg::ACT_CANCEL && pos_reg == start_reg) begin
                    state_next = teq_pkg::ST_DN_L;
                end else begin
                    state_next = teq_pkg::ST_EMIT_FINAL;
                end
            end
            teq_pkg::ST_UP_PUT: begin
                if (mode_reg == teq_pkg::ACT_CANCEL && pos_reg == start_reg) begin
                    state_next = teq_pkg::ST_DN_L;
                end else begin
                    state_next = teq_pkg::ST_EMIT_FINAL;
                end
            end
            teq_pkg::ST_DN_L: begin
                if (left_w >= occ_w) begin
                    state_next = (mode_reg == teq_pkg::ACT_TICK) ? teq_pkg::ST_TICK_RD
                                                                 : teq_pkg::ST_EMIT_FINAL;
                end else begin
                    state_next = teq_pkg::ST_DN_R;
                end
            end
            teq_pkg::ST_DN_R: state_next = teq_pkg::ST_DN_CMP;
            teq_pkg::ST_DN_CMP: begin
                if (dn_swap) begin
                    state_next = teq_pkg::ST_DN_L;
                end else begin
                    state_next = (mode_reg == teq_pkg::ACT_TICK) ? teq_pkg::ST_TICK_RD
                                                                 : teq_pkg::ST_EMIT_FINAL;
                end
            end
            teq_pkg::ST_TICK_RD: begin
                if (occ_reg == '0 || cnt_reg == teq_pkg::CNT_W'(teq_pkg::MAX_RESULTS)) begin
                    state_next = teq_pkg::ST_TICK_END;
                end else begin
                    state_next = teq_pkg::ST_TICK_CHK;
                end
            end
            teq_pkg::ST_TICK_CHK: begin
                if (rd_entry.trig <= now_reg) begin
                    state_next = have_pend_reg ? teq_pkg::ST_TICK_EMIT : teq_pkg::ST_TICK_POP;
                end else begin
                    state_next = teq_pkg::ST_TICK_END;
                end
            end
            teq_pkg::ST_TICK_EMIT: begin
                if (out_free) begin
                    state_next = teq_pkg::ST_TICK_POP;
                end
            end
            teq_pkg::ST_TICK_POP: begin
                state_next = (occ_m1 != '0) ? teq_pkg::ST_TICK_LAST : teq_pkg::ST_TICK_RD;
            end
            teq_pkg::ST_TICK_LAST: state_next = teq_pkg::ST_DN_L;
            teq_pkg::ST_TICK_END: begin
                if (!have_pend_reg || out_free) begin
                    state_next = teq_pkg::ST_IDLE;
                end
            end
            teq_pkg::ST_SCAN_RD: state_next = teq_pkg::ST_SCAN_CMP;
            teq_pkg::ST_SCAN_CMP: begin
                if (rd_entry.ident == cid_reg) begin
                    state_next = (teq_pkg::OCC_W'(scan_reg) == occ_m1) ? teq_pkg::ST_EMIT_FINAL
                                                                       : teq_pkg::ST_CAN_LAST;
                end else if (scan_p1 >= occ_reg) begin
                    state_next = teq_pkg::ST_EMIT_FINAL;
                end else begin
                    state_next = teq_pkg::ST_SCAN_RD;
                end
            end
            teq_pkg::ST_CAN_LAST: begin
                state_next = (scan_reg == '0) ? teq_pkg::ST_UP_PUT : teq_pkg::ST_UP_RD;
            end
            teq_pkg::ST_EMIT_FINAL: begin
                if (out_free) begin
                    state_next = teq_pkg::ST_IDLE;
                end
            end
            default: state_next = teq_pkg::ST_IDLE;
        endcase
    end

    // Datapath, RAM control and output register loads.
    always_comb begin
        mode_next      = mode_reg;
        occ_next       = occ_reg;
        last_id_next   = last_id_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        scan_next      = scan_reg;
        has_right_next = has_right_reg;
        cnt_next       = cnt_reg;
        have_pend_next = have_pend_reg;
        x_next         = x_reg;
        left_next      = left_reg;
        root_next      = root_reg;
        cid_next       = cid_reg;
        now_next       = now_reg;
        pend_kind_next = pend_kind_reg;
        pend_id_next   = pend_id_reg;
        pend_tag_next  = pend_tag_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_kind_next    = m_kind_reg;
        m_id_next      = m_id_reg;
        m_tag_next     = m_tag_reg;
        m_last_next    = m_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = x_reg;
        ram_raddr      = '0;

        unique case (state_reg)
            teq_pkg::ST_IDLE: begin
                if (accept) begin
                    cid_next = s_cancel_id;
                    now_next = s_current_time;
                    case (s_action)
                        teq_pkg::ACT_SCHEDULE: begin
                            mode_next = teq_pkg::ACT_SCHEDULE;
                            if (full) begin
                                pend_kind_next = teq_pkg::KIND_FULL;
                                pend_id_next   = 32'd0;
                                pend_tag_next  = 32'd0;
                            end else begin
                                last_id_next   = id_new;
                                x_next.trig    = s_trigger_time;
                                x_next.ident   = id_new;
                                x_next.tag     = s_event_payload;
                                pos_next       = teq_pkg::IDX_W'(occ_reg);
                                start_next     = teq_pkg::IDX_W'(occ_reg);
                                occ_next       = occ_reg + 1'b1;
                                pend_kind_next = teq_pkg::KIND_SCHEDULED;
                                pend_id_next   = id_new;
                                pend_tag_next  = 32'd0;
                            end
                        end
                        teq_pkg::ACT_CANCEL: begin
                            mode_next      = teq_pkg::ACT_CANCEL;
                            scan_next      = '0;
                            pend_kind_next = teq_pkg::KIND_NOT_FOUND;
                            pend_id_next   = 32'd0;
                            pend_tag_next  = 32'd0;
                        end
                        teq_pkg::ACT_TICK: begin
                            mode_next      = teq_pkg::ACT_TICK;
                            cnt_next       = '0;
                            have_pend_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            teq_pkg::ST_UP_RD: begin
                ram_raddr = parent_idx;
            end
            teq_pkg::ST_UP_CMP: begin
                ram_we = 1'b1;
                if (up_less) begin
                    // Parent moves down into the hole.
                    ram_wdata = rd_entry;
                    pos_next  = parent_idx;
                end
            end
            teq_pkg::ST_UP_PUT: begin
                ram_we = 1'b1;
            end
            teq_pkg::ST_DN_L: begin
                if (left_w >= occ_w) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr = teq_pkg::IDX_W'(left_w);
                end
            end
            teq_pkg::ST_DN_R: begin
                left_next      = rd_entry;
                has_right_next = (right_w < occ_w);
                ram_raddr      = teq_pkg::IDX_W'(right_w);
            end
            teq_pkg::ST_DN_CMP: begin
                ram_we = 1'b1;
                if (dn_swap) begin
                    // The smaller child moves up into the hole.
                    ram_wdata = pick_entry;
                    pos_next  = pick_idx;
                end
            end
            teq_pkg::ST_TICK_RD: begin
                ram_raddr = '0;
            end
            teq_pkg::ST_TICK_CHK: begin
                root_next = rd_entry;
            end
            teq_pkg::ST_TICK_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = pend_kind_reg;
                    m_id_next    = pend_id_reg;
                    m_tag_next   = pend_tag_reg;
                    m_last_next  = 1'b0;
                end
            end
            teq_pkg::ST_TICK_POP: begin
                pend_kind_next = teq_pkg::KIND_FIRED;
                pend_id_next   = root_reg.ident;
                pend_tag_next  = root_reg.tag;
                have_pend_next = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                occ_next       = occ_m1;
                ram_raddr      = teq_pkg::IDX_W'(occ_m1);
            end
            teq_pkg::ST_TICK_LAST: begin
                x_next   = rd_entry;
                pos_next = '0;
            end
            teq_pkg::ST_TICK_END: begin
                if (have_pend_reg && out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = pend_kind_reg;
                    m_id_next    = pend_id_reg;
                    m_tag_next   = pend_tag_reg;
                    m_last_next  = 1'b1;
                end
            end
            teq_pkg::ST_SCAN_RD: begin
                ram_raddr = scan_reg;
            end
            teq_pkg::ST_SCAN_CMP: begin
                if (rd_entry.ident == cid_reg) begin
                    pend_kind_next = teq_pkg::KIND_CANCELLED;
                    pend_id_next   = cid_reg;
                    pend_tag_next  = rd_entry.tag;
                    occ_next       = occ_m1;
                    ram_raddr      = teq_pkg::IDX_W'(occ_m1);
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            teq_pkg::ST_CAN_LAST: begin
                x_next     = rd_entry;
                pos_next   = scan_reg;
                start_next = scan_reg;
            end
            teq_pkg::ST_EMIT_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = pend_kind_reg;
                    m_id_next    = pend_id_reg;
                    m_tag_next   = pend_tag_reg;
                    m_last_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= teq_pkg::ST_IDLE;
            mode_reg      <= teq_pkg::ACT_SCHEDULE;
            occ_reg       <= '0;
            last_id_reg   <= '0;
            pos_reg       <= '0;
            start_reg     <= '0;
            scan_reg      <= '0;
            has_right_reg <= 1'b0;
            cnt_reg       <= '0;
            have_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            occ_reg       <= occ_next;
            last_id_reg   <= last_id_next;
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            scan_reg      <= scan_next;
            has_right_reg <= has_right_next;
            cnt_reg       <= cnt_next;
            have_pend_reg <= have_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        left_reg      <= left_next;
        root_reg      <= root_next;
        cid_reg       <= cid_next;
        now_reg       <= now_next;
        pend_kind_reg <= pend_kind_next;
        pend_id_reg   <= pend_id_next;
        pend_tag_reg  <= pend_tag_next;
        m_kind_reg    <= m_kind_next;
        m_id_reg      <= m_id_next;
        m_tag_reg     <= m_tag_next;
        m_last_reg    <= m_last_next;
    end

endmodule

// ===== sim/timed_event_heap_queue_checker.sv =====
// ----------------------------------------------------------------------------
// Timed event heap queue checker
// Watches both channels, keeps its own heap, and compares every result.
// ----------------------------------------------------------------------------
module timed_event_heap_queue_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [47:0] s_trigger_time,
    input  logic [31:0] s_event_payload,
    input  logic [31:0] s_cancel_id,
    input  logic [47:0] s_current_time,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_result_kind,
    input  logic [31:0] m_evt_ident,
    input  logic [31:0] m_payload_out,
    input  logic        m_last_of_run,
    output int          err_count,
    output int          pending
);

    typedef struct {
        teq_pkg::kind_t kind;
        logic [31:0]    id;
        logic [31:0]    tag;
        logic           last;
    } event_result_t;

    logic [teq_pkg::TIME_W-1:0] slot_trig [teq_pkg::CAPACITY];
    logic [teq_pkg::WORD_W-1:0] slot_id   [teq_pkg::CAPACITY];
    logic [teq_pkg::WORD_W-1:0] slot_tag  [teq_pkg::CAPACITY];
    int                         fill;
    logic [teq_pkg::WORD_W-1:0] id_counter;
    event_result_t              awaited [$];

    task automatic report_mismatch(input string what, input logic [47:0] want,
                                   input logic [47:0] got);
        $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
        err_count++;
    endtask

    task automatic swap_slots(input int a, input int b);
        logic [teq_pkg::TIME_W-1:0] t;
        logic [teq_pkg::WORD_W-1:0] i;
        logic [teq_pkg::WORD_W-1:0] g;
        t = slot_trig[a]; i = slot_id[a]; g = slot_tag[a];
        slot_trig[a] = slot_trig[b]; slot_id[a] = slot_id[b]; slot_tag[a] = slot_tag[b];
        slot_trig[b] = t; slot_id[b] = i; slot_tag[b] = g;
    endtask

    task automatic bubble_up(input int p);
        int par;
        while (p > 0) begin
            par = (p - 1) / 2;
            if (slot_trig[p] >= slot_trig[par]) return;
            swap_slots(p, par);
            p = par;
        end
    endtask

    task automatic bubble_down(input int p);
        int l;
        int pick;
        while (1) begin
            l = 2 * p + 1;
            if (l >= fill) return;
            pick = l;
            // Ties between the children go to the right one.
            if (l + 1 < fill && slot_trig[l] >= slot_trig[l + 1]) pick = l + 1;
            if (slot_trig[p] <= slot_trig[pick]) return;
            swap_slots(p, pick);
            p = pick;
        end
    endtask

    task automatic push_result(input teq_pkg::kind_t k, input logic [31:0] id,
                               input logic [31:0] tag);
        event_result_t r;
        r.kind = k; r.id = id; r.tag = tag; r.last = 1'b0;
        awaited.push_back(r);
    endtask

    task automatic predict_command(input logic [1:0] act, input logic [47:0] trig,
                                   input logic [31:0] tag, input logic [31:0] cid,
                                   input logic [47:0] now);
        int before_n;
        int hit;
        logic [31:0] found_tag;
        before_n = awaited.size();
        hit = -1;
        case (act)
            teq_pkg::ACT_SCHEDULE: begin
                if (fill >= teq_pkg::CAPACITY) begin
                    push_result(teq_pkg::KIND_FULL, '0, '0);
                end else begin
                    id_counter = id_counter + 1'b1;
                    if (id_counter == 32'd0) id_counter = 32'd1;
                    slot_trig[fill] = trig; slot_id[fill] = id_counter; slot_tag[fill] = tag;
                    fill++;
                    bubble_up(fill - 1);
                    push_result(teq_pkg::KIND_SCHEDULED, id_counter, '0);
                end
            end
            teq_pkg::ACT_CANCEL: begin
                for (int i = 0; cid != 0 && i < fill; i++) begin
                    if (hit < 0 && slot_id[i] == cid) hit = i;
                end
                if (hit >= 0) begin
                    found_tag = slot_tag[hit];
                    fill--;
                    if (fill != hit) begin
                        slot_trig[hit] = slot_trig[fill];
                        slot_id[hit] = slot_id[fill];
                        slot_tag[hit] = slot_tag[fill];
                        bubble_up(hit);
                        bubble_down(hit);
                    end
                    push_result(teq_pkg::KIND_CANCELLED, cid, found_tag);
                end else begin
                    push_result(teq_pkg::KIND_NOT_FOUND, '0, '0);
                end
            end
            teq_pkg::ACT_TICK: begin
                while (awaited.size() - before_n < teq_pkg::MAX_RESULTS && fill > 0
                       && slot_trig[0] <= now) begin
                    push_result(teq_pkg::KIND_FIRED, slot_id[0], slot_tag[0]);
                    fill--;
                    if (fill > 0) begin
                        slot_trig[0] = slot_trig[fill];
                        slot_id[0] = slot_id[fill];
                        slot_tag[0] = slot_tag[fill];
                        bubble_down(0);
                    end
                end
            end
            default: ;
        endcase
        if (awaited.size() > before_n) awaited[awaited.size() - 1].last = 1'b1;
    endtask

    initial begin
        err_count = 0;
        pending = 0;
        fill = 0;
        id_counter = '0;
    end

    always @(posedge aclk) begin
        event_result_t w;
        if (aresetn) begin
            // Results are checked first; none can belong to a command taken at this edge.
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    report_mismatch("unexpected result, evt_ident", '0, m_evt_ident);
                end else begin
                    w = awaited.pop_front();
                    if (m_result_kind !== w.kind)
                        report_mismatch("result_kind", w.kind, m_result_kind);
                    if (m_evt_ident !== w.id) report_mismatch("evt_ident", w.id, m_evt_ident);
                    if (m_payload_out !== w.tag)
                        report_mismatch("payload_out", w.tag, m_payload_out);
                    if (m_last_of_run !== w.last)
                        report_mismatch("last_of_run", w.last, m_last_of_run);
                end
            end
            if (s_valid && s_ready)
                predict_command(s_action, s_trigger_time, s_event_payload, s_cancel_id,
                                s_current_time);
        end
        pending = awaited.size();
    end

endmodule

// ===== sim/timed_event_heap_queue_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Timed event heap queue unit testbench
// Drives schedule, cancel and tick commands with random idling on both
// channels; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module timed_event_heap_queue_unit_tb;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [47:0] s_trigger_time;
    logic [31:0] s_event_payload;
    logic [31:0] s_cancel_id;
    logic [47:0] s_current_time;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_result_kind;
    logic [31:0] m_evt_ident;
    logic [31:0] m_payload_out;
    logic        m_last_of_run;
    int          err_count;
    int          pending;

    // Stimulus bookkeeping. The schedule count lets cancels aim at IDs that
    // were likely issued, and the emulated clock mostly moves forward but can jump.
    logic [47:0] sys_now;
    int          n_sched;
    int          n_cancel;
    int          n_tick;
    int          n_other;
    bit          quiet;
    int          rdy_hold;

    timed_event_heap_queue_unit u_top (.*);

    timed_event_heap_queue_checker u_chk (.*);

    always begin
        aclk = 1'b0; #1;
        aclk = 1'b1; #1;
    end

    initial begin
        #10_000_000;
        $display("timed_event_heap_queue_unit_tb: errors");
        $finish;
    end

    // The receiver stalls in random bursts, except in the quiet tail.
    always @(posedge aclk) begin
        if (rdy_hold != 0) begin
            rdy_hold <= rdy_hold - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            m_ready  <= 1'b0;
            rdy_hold <= $urandom_range(0, 5);
        end else begin
            m_ready  <= 1'b1;
            rdy_hold <= quiet ? 0 : $urandom_range(0, 8);
        end
    end

    // Presents one command and holds it until the transfer happens. It is
    // always entered just after a rising edge, so the single nonblocking
    // update per step rule holds even when commands follow back to back.
    task automatic send_command(input logic [1:0] act, input logic [47:0] trig,
                                input logic [31:0] tag, input logic [31:0] cid,
                                input logic [47:0] now);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_action        <= act;
        s_trigger_time  <= trig;
        s_event_payload <= tag;
        s_cancel_id     <= cid;
        s_current_time  <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        case (act)
            teq_pkg::ACT_SCHEDULE: n_sched++;
            teq_pkg::ACT_CANCEL:   n_cancel++;
            teq_pkg::ACT_TICK:     n_tick++;
            default:               n_other++;
        endcase
    endtask

    function automatic logic [47:0] any_time();
        return {16'($urandom_range(0, 16'hFFFF)), $urandom};
    endfunction

    // One command of the random mix. Most are well formed: triggers just ahead
    // of the emulated clock, cancels of IDs that were handed out, and ticks
    // that move the clock on a little. The rest are extreme or plain noise.
    task automatic random_command();
        int pick;
        logic [47:0] trig;
        logic [31:0] cid;
        pick = $urandom_range(0, 99);
        trig = sys_now + $urandom_range(0, 40);
        if ($urandom_range(0, 9) == 0) trig = any_time();
        else if ($urandom_range(0, 9) == 0) trig = sys_now;
        cid = $urandom_range(1, n_sched + 2);
        if ($urandom_range(0, 9) == 0) cid = $urandom;
        if (pick < 45) begin
            send_command(teq_pkg::ACT_SCHEDULE, trig, $urandom, $urandom, any_time());
        end else if (pick < 70) begin
            send_command(teq_pkg::ACT_CANCEL, any_time(), $urandom, cid, any_time());
        end else if (pick < 95) begin
            sys_now = sys_now + $urandom_range(0, 30);
            if ($urandom_range(0, 19) == 0) sys_now = any_time();
            send_command(teq_pkg::ACT_TICK, any_time(), $urandom, $urandom, sys_now);
        end else begin
            send_command(ACT_UNUSED, any_time(), $urandom, $urandom, any_time());
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_action        <= teq_pkg::ACT_SCHEDULE;
        s_trigger_time  <= '0;
        s_event_payload <= '0;
        s_cancel_id     <= '0;
        s_current_time  <= '0;
        m_ready         <= 1'b0;
        rdy_hold        = 0;
        quiet           = 1'b0;
        sys_now         = '0;
        n_sched = 0; n_cancel = 0; n_tick = 0; n_other = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: field extremes, ties, the unused code, and cancels of
        // ID zero, of an unknown ID, of a live ID and on an empty heap.
        send_command(teq_pkg::ACT_TICK, '0, '0, '0, TIME_MAX);
        send_command(teq_pkg::ACT_CANCEL, '0, '0, '0, '0);
        send_command(teq_pkg::ACT_SCHEDULE, '0, '0, '0, '0);
        send_command(teq_pkg::ACT_SCHEDULE, TIME_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TIME_MAX);
        send_command(teq_pkg::ACT_SCHEDULE, 48'd5, 32'h1111_0001, '0, '0);
        send_command(teq_pkg::ACT_SCHEDULE, 48'd5, 32'h1111_0002, '0, '0);
        send_command(teq_pkg::ACT_SCHEDULE, 48'd5, 32'h1111_0003, '0, '0);
        send_command(teq_pkg::ACT_SCHEDULE, 48'd3, 32'h1111_0004, '0, '0);
        send_command(teq_pkg::ACT_CANCEL, '0, '0, 32'd0, '0);
        send_command(teq_pkg::ACT_CANCEL, '0, '0, 32'hFFFF_FFFF, '0);
        send_command(teq_pkg::ACT_CANCEL, '0, '0, 32'd4, '0);
        send_command(teq_pkg::ACT_CANCEL, '0, '0, 32'd1, '0);
        send_command(teq_pkg::ACT_CANCEL, '0, '0, 32'd1, '0);
        send_command(ACT_UNUSED, TIME_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TIME_MAX);
        send_command(teq_pkg::ACT_TICK, TIME_MAX, '0, '0, 48'd4);
        send_command(teq_pkg::ACT_TICK, '0, '0, '0, 48'd5);
        send_command(teq_pkg::ACT_TICK, '0, '0, '0, TIME_MAX);
        send_command(teq_pkg::ACT_CANCEL, '0, '0, 32'd2, '0);

        // Random mix with idling on both sides.
        repeat (170) random_command();

        // Fill the heap past its capacity, then let everything fire in one tick.
        repeat (36) send_command(teq_pkg::ACT_SCHEDULE, sys_now + $urandom_range(0, 7),
                                 $urandom, $urandom, any_time());
        send_command(teq_pkg::ACT_CANCEL, '0, '0, $urandom_range(1, n_sched), '0);
        send_command(teq_pkg::ACT_SCHEDULE, sys_now, $urandom, '0, '0);
        send_command(teq_pkg::ACT_SCHEDULE, sys_now, $urandom, '0, '0);
        send_command(teq_pkg::ACT_TICK, '0, '0, '0, TIME_MAX);

        // Hold the sender until every expected result has come back.
        s_valid <= 1'b0;
        wait_drained();

        repeat (80) random_command();

        // Quiet tail: no idling on either side.
        quiet = 1'b1;
        repeat (60) random_command();
        s_valid <= 1'b0;

        wait_drained();
        repeat (200) @(posedge aclk);
        @(negedge aclk);
        $display("Covered %0d schedules, %0d cancels, %0d ticks and %0d unused codes,",
                 n_sched, n_cancel, n_tick, n_other);
        $display("including a full heap, equal triggers and bulk firing under stalls.");
        if (err_count == 0 && pending == 0) begin
            $display("timed_event_heap_queue_unit_tb: clean");
        end else begin
            $display("timed_event_heap_queue_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/teq_pkg.sv
design/teq_ram.sv
design/timed_event_heap_queue_unit.sv
sim/timed_event_heap_queue_checker.sv
sim/timed_event_heap_queue_unit_tb.sv
